// File: hdl/max_key_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Priority queue assertion macros
// Shared concurrent assertion forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef MAX_KEY_PRIORITY_QUEUE_MACROS_SVH
`define MAX_KEY_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("priority queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define MKPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("priority queue check failed");

`endif

// File: hdl/mkpq_pkg.sv
// ----------------------------------------------------------------------------
// Priority queue package
// Entry layout, neighbour slot and control types, codes and default sizes.
// ----------------------------------------------------------------------------
package mkpq_pkg;

   localparam int KEY_W            = 7;
   localparam int IDENT_W          = 16;
   localparam int STOP_W           = 8;
   localparam int STATUS_W         = 2;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [IDENT_W-1:0] ident;
      logic [STOP_W-1:0]  stop;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   typedef struct packed {
      logic insert;
      logic extract;
   } cell_ctrl_type;

endpackage

// File: hdl/mkpq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// One place of the sorted chain: holds an entry, takes the new entry, its
// upper neighbour's entry or its lower neighbour's entry.
// ----------------------------------------------------------------------------
module mkpq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mkpq_pkg::cell_ctrl_type ctrl,
   input  mkpq_pkg::entry_type    new_entry,
   input  logic                   prev_push,
   input  mkpq_pkg::slot_type     prev_slot,
   input  mkpq_pkg::slot_type     next_slot,
   output mkpq_pkg::slot_type     slot,
   output logic                   push
);

   mkpq_pkg::slot_type slot_ff;
   mkpq_pkg::slot_type slot_in;

   // The new entry goes behind every entry whose key is at least as large.
   assign push = !slot_ff.valid || (new_entry.key > slot_ff.entry.key);

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.extract) begin
         slot_in = next_slot;
      end else if (ctrl.insert && push) begin
         if (prev_push) begin
            slot_in = prev_slot;
         end else begin
            slot_in.valid = 1'b1;
            slot_in.entry = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.entry <= slot_in.entry;
   end

   assign slot = slot_ff;

endmodule

// File: hdl/max_key_priority_queue.sv
// ----------------------------------------------------------------------------
// Max-key priority queue
// Bounded queue that serves the largest key first, oldest first on ties.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                   Handshake
// request   req_func req_key req_ident req_stop_code start / busy
// response  rsp_status rsp_out_key rsp_out_ident    rsp_strobe, one cycle
//           rsp_out_stop rsp_occupancy
//
// For every transaction the cells update at the accepting edge, and the
// response is shown in the following cycle while busy is high.
// The row of cells is kept sorted by key, largest at the head, so an insert
// and an extract each update every cell together at the accepting edge.
// Reset is synchronous and clears the valid bits, the count and busy; no
// clearing pass is needed. The receiver cannot stall the response.
//
`include "max_key_priority_queue_macros.svh"

module max_key_priority_queue #(
   parameter int CAPACITY = mkpq_pkg::CAPACITY_DEFAULT,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [mkpq_pkg::KEY_W-1:0]    req_key,
   input  logic [mkpq_pkg::IDENT_W-1:0]  req_ident,
   input  logic [mkpq_pkg::STOP_W-1:0]   req_stop_code,
   output logic                          rsp_strobe,
   output logic [mkpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [mkpq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [mkpq_pkg::IDENT_W-1:0]  rsp_out_ident,
   output logic [mkpq_pkg::STOP_W-1:0]   rsp_out_stop,
   output logic [CNT_W-1:0]              rsp_occupancy
);

   // Handshake and command decode.
   logic accept;
   logic is_extract;
   logic full;
   logic empty;
   logic insert_go;
   logic extract_go;

   logic busy_ff;
   logic busy_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [mkpq_pkg::STATUS_W-1:0] status_ff;
   logic [mkpq_pkg::STATUS_W-1:0] status_in;
   mkpq_pkg::entry_type           out_entry_ff;
   mkpq_pkg::entry_type           out_entry_in;
   logic [CNT_W-1:0]              occupancy_ff;

   mkpq_pkg::cell_ctrl_type ctrl;
   mkpq_pkg::entry_type     new_entry;
   mkpq_pkg::slot_type      cell_slot [CAPACITY];
   logic [CAPACITY-1:0]     cell_push;
   logic [CAPACITY-1:0]     cell_valid;

   assign accept     = start && !busy_ff;
   assign is_extract = (req_func == mkpq_pkg::FUNC_EXTRACT);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign insert_go  = accept && !is_extract && !full;
   assign extract_go = accept && is_extract && !empty;

   assign ctrl.insert  = insert_go;
   assign ctrl.extract = extract_go;

   assign new_entry.key   = req_key;
   assign new_entry.ident = req_ident;
   assign new_entry.stop  = req_stop_code;

   // The chain of cells. Each cell sees only its two neighbours: the one
   // above hands down its entry on an insert, the one below hands up its
   // entry on an extract. The head cell always holds the entry to serve.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               prev_push;
      mkpq_pkg::slot_type prev_slot;
      mkpq_pkg::slot_type next_slot;

      if (i == 0) begin : g_head
         assign prev_push = 1'b0;
         assign prev_slot = '0;
      end else begin : g_body
         assign prev_push = cell_push[i-1];
         assign prev_slot = cell_slot[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_slot = '0;
      end else begin : g_inner
         assign next_slot = cell_slot[i+1];
      end

      mkpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_entry (new_entry),
         .prev_push (prev_push),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .slot      (cell_slot[i]),
         .push      (cell_push[i])
      );

      assign cell_valid[i] = cell_slot[i].valid;
   end

   // Occupancy count and the response for this transaction.
   always_comb begin
      count_in     = count_ff;
      status_in    = mkpq_pkg::STATUS_DONE;
      out_entry_in = '0;
      if (insert_go) begin
         count_in = count_ff + 1'b1;
      end else if (extract_go) begin
         count_in     = count_ff - 1'b1;
         out_entry_in = cell_slot[0].entry;
      end
      if (!is_extract && full) begin
         status_in = mkpq_pkg::STATUS_FULL;
      end else if (is_extract && empty) begin
         status_in = mkpq_pkg::STATUS_EMPTY;
      end
   end

   assign busy_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      if (accept) begin
         status_ff    <= status_in;
         out_entry_ff <= out_entry_in;
         occupancy_ff <= count_in;
      end
   end

   assign busy          = busy_ff;
   assign rsp_strobe    = busy_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_key   = out_entry_ff.key;
   assign rsp_out_ident = out_entry_ff.ident;
   assign rsp_out_stop  = out_entry_ff.stop;
   assign rsp_occupancy = occupancy_ff;

   // Valid cells form an unbroken run from the head, as many as the count.
   `MKPQ_ASSERT_SAME(a_valid_prefix, clock, reset, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
   `MKPQ_ASSERT_SAME(a_count_match, clock, reset, 1'b1, $countones(cell_valid) == count_ff)
   `MKPQ_ASSERT_NEXT(a_insert_count, clock, reset, insert_go, count_ff == $past(count_ff) + 1'b1)
   `MKPQ_ASSERT_SAME(a_empty_zero, clock, reset,
      rsp_strobe && (rsp_status == mkpq_pkg::STATUS_EMPTY), rsp_occupancy == '0)

   // Keys never rise towards the tail.
   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
      `MKPQ_ASSERT_SAME(a_sorted, clock, reset, cell_slot[j+1].valid,
         cell_slot[j].entry.key >= cell_slot[j+1].entry.key)
   end

endmodule
